// File: rtl/sm83_alu_flags_unit_assert.svh
// Assertion macros for the SM83 ALU flags unit.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SM83_ALU_FLAGS_UNIT_ASSERT_SVH
`define SM83_ALU_FLAGS_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SM83AF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define SM83AF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sm83af_pkg.sv
// Shared types and constants of the SM83 ALU flags unit.
// No dependencies; imported by every module of the unit.
`timescale 1ns / 1ps
`default_nettype none

package sm83af_pkg;

    typedef enum logic [3:0] {
        CMD_ADD   = 4'd0,
        CMD_ADC   = 4'd1,
        CMD_SUB   = 4'd2,
        CMD_SBC   = 4'd3,
        CMD_AND   = 4'd4,
        CMD_XOR   = 4'd5,
        CMD_OR    = 4'd6,
        CMD_CP    = 4'd7,
        CMD_INC8  = 4'd8,
        CMD_DEC8  = 4'd9,
        CMD_DAA   = 4'd10,
        CMD_CPL   = 4'd11,
        CMD_ADD16 = 4'd12,
        CMD_ADDSP = 4'd13,
        CMD_INC16 = 4'd14,
        CMD_DEC16 = 4'd15
    } alu_cmd_t;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [7:0] DAA_ADJ_HI = 8'h60;
    localparam logic [7:0] DAA_ADJ_LO = 8'h06;
    localparam logic [7:0] DAA_LIMIT  = 8'h99;
    localparam logic [3:0] BCD_DIGIT_MAX = 4'd9;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [3:0]  flags;
        logic [15:0] wide_operand;
        logic [15:0] wide;
        logic [7:0]  operand;
        logic [7:0]  acc;
        alu_cmd_t    cmd;
    } alu_req_t;

    typedef struct packed {
        logic [3:0]  flags;
        logic [15:0] wide;
        logic [7:0]  acc;
    } alu_rsp_t;

endpackage

`default_nettype wire

// File: rtl/sm83af_in_stage.sv
// Input register of the SM83 ALU flags unit.
// Depends on sm83af_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sm83af_in_stage
    import sm83af_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   down_ready,
    output logic                   req_valid,
    output alu_req_t               req
);

    logic     valid_reg;
    logic     valid_next;
    alu_req_t req_reg;
    logic     accept;

    assign s_axis_tready = !valid_reg || down_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign valid_next    = accept || (valid_reg && !down_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold payload until the next transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.cmd          <= alu_cmd_t'(s_axis_tdata[3:0]);
            req_reg.acc          <= s_axis_tdata[11:4];
            req_reg.operand      <= s_axis_tdata[19:12];
            req_reg.wide         <= s_axis_tdata[35:20];
            req_reg.wide_operand <= s_axis_tdata[51:36];
            req_reg.flags        <= s_axis_tdata[55:52];
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

`default_nettype wire

// File: rtl/sm83af_alu.sv
// Combinational 8-bit and 16-bit ALU with flag generation.
// Depends on sm83af_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sm83af_alu
    import sm83af_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [7:0]  a;
    logic [7:0]  b;
    logic [15:0] w;
    logic [15:0] wb;
    logic [3:0]  f;
    logic        cin;
    logic        c_use;
    logic [8:0]  sum9;
    logic [4:0]  sum5;
    logic [8:0]  dif9;
    logic [4:0]  dif5;
    logic        daa_c;
    logic [7:0]  daa_hi;
    logic [7:0]  daa_lo;
    logic [7:0]  daa_val;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [15:0] sp_sum;
    logic [8:0]  sp_lo9;
    logic [4:0]  sp_lo5;
    logic [7:0]  acc_r;
    logic [15:0] wide_r;
    logic [3:0]  nf;

    assign a   = req.acc;
    assign b   = req.operand;
    assign w   = req.wide;
    assign wb  = req.wide_operand;
    assign f   = req.flags;
    assign cin = f[FLAG_C];

    assign c_use = (req.cmd == CMD_ADC || req.cmd == CMD_SBC) ? cin : 1'b0;

    assign sum9 = {1'b0, a} + {1'b0, b} + 9'(c_use);
    assign sum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(c_use);
    assign dif9 = {1'b0, a} - {1'b0, b} - 9'(c_use);
    assign dif5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - 5'(c_use);

    always_comb
    begin
        daa_c  = cin;
        daa_hi = 8'd0;
        daa_lo = 8'd0;
        if (!f[FLAG_N])
        begin
            if (cin || (a > DAA_LIMIT))
            begin
                daa_hi = DAA_ADJ_HI;
                daa_c  = 1'b1;
            end
            if (f[FLAG_H] || (a[3:0] > BCD_DIGIT_MAX))
            begin
                daa_lo = DAA_ADJ_LO;
            end
            daa_val = a + daa_hi + daa_lo;
        end
        else
        begin
            if (cin)
            begin
                daa_hi = DAA_ADJ_HI;
            end
            if (f[FLAG_H])
            begin
                daa_lo = DAA_ADJ_LO;
            end
            daa_val = a - daa_hi - daa_lo;
        end
    end

    assign sum17  = {1'b0, w} + {1'b0, wb};
    assign sum13  = {1'b0, w[11:0]} + {1'b0, wb[11:0]};
    assign sp_sum = w + {{8{b[7]}}, b};
    assign sp_lo9 = {1'b0, w[7:0]} + {1'b0, b};
    assign sp_lo5 = {1'b0, w[3:0]} + {1'b0, b[3:0]};

    always_comb
    begin
        acc_r  = a;
        wide_r = w;
        nf     = f;
        unique case (req.cmd)
            CMD_ADD, CMD_ADC:
            begin
                acc_r = sum9[7:0];
                nf    = {sum9[7:0] == 8'd0, 1'b0, sum5[4], sum9[8]};
            end
            CMD_SUB, CMD_SBC, CMD_CP:
            begin
                if (req.cmd != CMD_CP)
                begin
                    acc_r = dif9[7:0];
                end
                nf = {dif9[7:0] == 8'd0, 1'b1, dif5[4], dif9[8]};
            end
            CMD_AND:
            begin
                acc_r = a & b;
                nf    = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            CMD_XOR:
            begin
                acc_r = a ^ b;
                nf    = {(a ^ b) == 8'd0, 1'b0, 1'b0, 1'b0};
            end
            CMD_OR:
            begin
                acc_r = a | b;
                nf    = {(a | b) == 8'd0, 1'b0, 1'b0, 1'b0};
            end
            CMD_INC8:
            begin
                acc_r = a + 8'd1;
                nf    = {a == 8'hFF, 1'b0, a[3:0] == 4'hF, cin};
            end
            CMD_DEC8:
            begin
                acc_r = a - 8'd1;
                nf    = {a == 8'h01, 1'b1, a[3:0] == 4'h0, cin};
            end
            CMD_DAA:
            begin
                acc_r = daa_val;
                nf    = {daa_val == 8'd0, f[FLAG_N], 1'b0, daa_c};
            end
            CMD_CPL:
            begin
                acc_r = ~a;
                nf    = {f[FLAG_Z], 1'b1, 1'b1, cin};
            end
            CMD_ADD16:
            begin
                wide_r = sum17[15:0];
                nf     = {f[FLAG_Z], 1'b0, sum13[12], sum17[16]};
            end
            CMD_ADDSP:
            begin
                wide_r = sp_sum;
                nf     = {1'b0, 1'b0, sp_lo5[4], sp_lo9[8]};
            end
            CMD_INC16:
            begin
                wide_r = w + 16'd1;
            end
            CMD_DEC16:
            begin
                wide_r = w - 16'd1;
            end
        endcase
    end

    assign rsp.acc   = acc_r;
    assign rsp.wide  = wide_r;
    assign rsp.flags = nf;

endmodule

`default_nettype wire

// File: rtl/sm83af_out_stage.sv
// Result register of the SM83 ALU flags unit, driving the master stream.
// Depends on sm83af_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sm83af_out_stage
    import sm83af_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rsp_valid,
    input  alu_rsp_t               rsp,
    output logic                   up_ready,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic     valid_reg;
    logic     valid_next;
    alu_rsp_t rsp_reg;
    logic     load;

    assign up_ready   = !valid_reg || m_axis_tready;
    assign load       = rsp_valid && up_ready;
    assign valid_next = load || (valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'd0, rsp_reg.flags, rsp_reg.wide, rsp_reg.acc};

endmodule

`default_nettype wire

// File: rtl/sm83_alu_flags_unit.sv
// SM83 ALU flags unit: a two-stage stream pipeline; with the result side
// ready it does one registered ALU operation and accepts one transaction
// every cycle, set by the single ALU pass between the input and result
// registers. An accepted transaction passes the input register, the ALU and
// the result register. The unit keeps no architectural state. Input tdata, from
// bit 0: command[3:0], acc_in[7:0], operand[7:0], wide_in[15:0],
// wide_operand[15:0], flags_in[3:0] (Z N H C). Output tdata, from bit 0:
// acc_out[7:0], wide_out[15:0], flags_out[3:0], four zero bits.
// Depends on sm83af_pkg, sm83af_in_stage, sm83af_alu, sm83af_out_stage.
`timescale 1ns / 1ps
`default_nettype none

`include "sm83_alu_flags_unit_assert.svh"

module sm83_alu_flags_unit
    import sm83af_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // command, acc_in, operand, wide_in, wide_operand, flags_in
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // acc_out, wide_out, flags_out, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic       req_valid;
    alu_req_t   req;
    alu_rsp_t   rsp;
    logic       up_ready;
    logic       req_fire;
    logic       pipe_stalled;
    logic       wide_fire;
    logic       cp_fire;
    logic [7:0] out_acc;
    logic       out_n;

    sm83af_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .down_ready    (up_ready),
        .req_valid     (req_valid),
        .req           (req)
    );

    sm83af_alu u_alu (
        .req (req),
        .rsp (rsp)
    );

    sm83af_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .rsp_valid     (req_valid),
        .rsp           (rsp),
        .up_ready      (up_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    assign req_fire     = req_valid && up_ready;
    assign pipe_stalled = req_valid && m_axis_tvalid && !m_axis_tready;
    assign wide_fire    = req_fire && ((req.cmd == CMD_ADD16) || (req.cmd == CMD_ADDSP) ||
                                       (req.cmd == CMD_INC16) || (req.cmd == CMD_DEC16));
    assign cp_fire      = req_fire && (req.cmd == CMD_CP);
    assign out_acc      = m_axis_tdata[7:0];
    assign out_n        = m_axis_tdata[24 + FLAG_N];

    // backpressure only when both stages hold an item and the sink stalls
    `SM83AF_ASSERT_SAME(a_stall_full, !s_axis_tready, pipe_stalled, "input stalled early")
    `SM83AF_ASSERT_NEXT(a_advance, req_fire, m_axis_tvalid, "advanced item lost")
    `SM83AF_ASSERT_NEXT(a_wide_keeps_acc, wide_fire, out_acc == $past(req.acc), "acc changed")
    `SM83AF_ASSERT_NEXT(a_cp_keeps_acc, cp_fire, out_acc == $past(req.acc) && out_n, "bad CP")

endmodule

`default_nettype wire
